@@ hdl/sbc_pkg.sv @@
// sbc_pkg: shared types, constants and helpers of the colour-keyed sprite blitter
// used by every module of the block and by the channel interfaces
`default_nettype none

package sbc_pkg;

  // largest sprite or screen dimension
  localparam int unsigned MaxDim = 2048;

  // widths fixed by the register map and the word formats
  localparam int unsigned CoordW = 12;
  localparam int unsigned CfgW   = 12;
  localparam int unsigned PixW   = 16;
  localparam int unsigned IdxW   = 22;
  localparam int unsigned DataW  = 16;
  localparam int unsigned RegIdxW = 3;

  // widths that follow from the largest dimension
  localparam int unsigned CntW  = $clog2(MaxDim);
  localparam int unsigned DimW  = CntW + 1;
  localparam int unsigned PosW  = ((CoordW > CntW) ? CoordW : CntW) + 2;
  localparam int unsigned ProdW = ((CntW + DimW + 1) > IdxW) ? (CntW + DimW + 1) : IdxW;

  // register map
  typedef enum logic [RegIdxW-1:0] {
    REG_DEST_X        = 3'd0,
    REG_DEST_Y        = 3'd1,
    REG_SPRITE_WIDTH  = 3'd2,
    REG_SPRITE_HEIGHT = 3'd3,
    REG_SCREEN_WIDTH  = 3'd4,
    REG_SCREEN_HEIGHT = 3'd5,
    REG_KEY_COLOUR    = 3'd6,
    REG_KEY_ENABLE    = 3'd7
  } reg_idx_e;

  // configuration as seen by the datapath, dimensions already clamped
  typedef struct packed {
    logic signed [CoordW-1:0] dest_x;
    logic signed [CoordW-1:0] dest_y;
    logic [DimW-1:0]          sprite_w;
    logic [DimW-1:0]          sprite_h;
    logic [DimW-1:0]          screen_w;
    logic [DimW-1:0]          screen_h;
    logic [PixW-1:0]          key_colour;
    logic                     key_en;
  } cfg_t;

  // word held between the position stage and the address stage
  typedef struct packed {
    logic [PixW-1:0]        pixel;
    logic signed [PosW-1:0] sx;
    logic signed [PosW-1:0] sy;
    logic                   done;
  } pos_t;

  // zero or oversize dimension reads as the largest one
  function automatic logic [DimW-1:0] eff_dim(input logic [CfgW-1:0] v);
    logic [DimW-1:0] res;
    if ((v == '0) || (32'(v) > MaxDim)) begin
      res = DimW'(MaxDim);
    end else begin
      res = DimW'(v);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ hdl/sbc_if.sv @@
// sbc_if: valid/ready channel interfaces of the sprite blitter
// depends on sbc_pkg for the word widths
`default_nettype none

// sprite pixel channel
interface sbc_in_if;
  logic                       valid;
  logic                       ready;
  logic [sbc_pkg::PixW-1:0]   sprite_pixel;

  modport source (output valid, output sprite_pixel, input ready);
  modport sink   (input valid, input sprite_pixel, output ready);
endinterface

// framebuffer write channel
interface sbc_out_if;
  logic                       valid;
  logic                       ready;
  logic                       write_strobe;
  logic [sbc_pkg::IdxW-1:0]   pixel_index;
  logic [sbc_pkg::PixW-1:0]   pixel_value;
  logic                       sprite_done;

  modport source (output valid, output write_strobe, output pixel_index,
                  output pixel_value, output sprite_done, input ready);
  modport sink   (input valid, input write_strobe, input pixel_index,
                  input pixel_value, input sprite_done, output ready);
endinterface

`default_nettype wire

@@ hdl/sbc_cfg.sv @@
// sbc_cfg: configuration registers of the sprite blitter
// depends on sbc_pkg (register map, cfg_t, eff_dim)
`default_nettype none

module sbc_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [sbc_pkg::RegIdxW-1:0]   cfg_idx_i,
  input  wire logic [sbc_pkg::DataW-1:0]     cfg_data_i,
  output sbc_pkg::cfg_t                      cfg_o
);

  sbc_pkg::cfg_t cfg_q, cfg_d;
  sbc_pkg::reg_idx_e idx;

  assign idx = sbc_pkg::reg_idx_e'(cfg_idx_i);

  // register write decode, dimensions clamped on the way in
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (idx)
        sbc_pkg::REG_DEST_X:
          cfg_d.dest_x = $signed(cfg_data_i[sbc_pkg::CoordW-1:0]);
        sbc_pkg::REG_DEST_Y:
          cfg_d.dest_y = $signed(cfg_data_i[sbc_pkg::CoordW-1:0]);
        sbc_pkg::REG_SPRITE_WIDTH:
          cfg_d.sprite_w = sbc_pkg::eff_dim(cfg_data_i[sbc_pkg::CfgW-1:0]);
        sbc_pkg::REG_SPRITE_HEIGHT:
          cfg_d.sprite_h = sbc_pkg::eff_dim(cfg_data_i[sbc_pkg::CfgW-1:0]);
        sbc_pkg::REG_SCREEN_WIDTH:
          cfg_d.screen_w = sbc_pkg::eff_dim(cfg_data_i[sbc_pkg::CfgW-1:0]);
        sbc_pkg::REG_SCREEN_HEIGHT:
          cfg_d.screen_h = sbc_pkg::eff_dim(cfg_data_i[sbc_pkg::CfgW-1:0]);
        sbc_pkg::REG_KEY_COLOUR:
          cfg_d.key_colour = cfg_data_i[sbc_pkg::PixW-1:0];
        sbc_pkg::REG_KEY_ENABLE:
          cfg_d.key_en = cfg_data_i[0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dest_x     <= '0;
      cfg_q.dest_y     <= '0;
      cfg_q.sprite_w   <= sbc_pkg::DimW'(1);
      cfg_q.sprite_h   <= sbc_pkg::DimW'(1);
      cfg_q.screen_w   <= sbc_pkg::eff_dim(sbc_pkg::CfgW'(1024));
      cfg_q.screen_h   <= sbc_pkg::eff_dim(sbc_pkg::CfgW'(768));
      cfg_q.key_colour <= '0;
      cfg_q.key_en     <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ hdl/sbc_pos.sv @@
// sbc_pos: column/row counters and screen position stage of the sprite blitter
// depends on sbc_pkg (cfg_t, pos_t) and sbc_in_if
`default_nettype none

module sbc_pos (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  sbc_pkg::cfg_t      cfg_i,
  sbc_in_if.sink             pix_in,
  input  wire logic          adv_i,
  output logic               vld_o,
  output sbc_pkg::pos_t      pos_o
);

  logic [sbc_pkg::CntW-1:0] col_q, col_d, row_q, row_d;
  logic                     vld_q, vld_d;
  sbc_pkg::pos_t            pos_q, pos_d;
  logic                     accept, row_end, last_row;
  logic [sbc_pkg::DimW-1:0] col_inc, row_inc;

  // a word may enter when the stage is empty or moving on
  assign pix_in.ready = !vld_q || adv_i;
  assign accept       = pix_in.valid && pix_in.ready;

  // end of row and end of sprite tests, also catch a counter past a shrunk size
  assign col_inc  = sbc_pkg::DimW'(col_q) + sbc_pkg::DimW'(1);
  assign row_inc  = sbc_pkg::DimW'(row_q) + sbc_pkg::DimW'(1);
  assign row_end  = col_inc >= cfg_i.sprite_w;
  assign last_row = row_inc >= cfg_i.sprite_h;

  // counter update on each accepted word
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (row_end) begin
        col_d = '0;
        row_d = last_row ? '0 : col_inc[sbc_pkg::CntW-1:0] & '0 | row_inc[sbc_pkg::CntW-1:0];
      end else begin
        col_d = col_inc[sbc_pkg::CntW-1:0];
      end
    end
  end

  // screen position of the incoming pixel
  always_comb begin
    pos_d.pixel = pix_in.sprite_pixel;
    pos_d.sx    = sbc_pkg::PosW'(cfg_i.dest_x) + $signed({2'b00, col_q});
    pos_d.sy    = sbc_pkg::PosW'(cfg_i.dest_y) + $signed({2'b00, row_q});
    pos_d.done  = row_end && last_row;
  end

  assign vld_d = accept || (vld_q && !adv_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      vld_q <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      vld_q <= vld_d;
    end
  end

  // payload register, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pos_q <= pos_d;
    end
  end

  assign vld_o = vld_q;
  assign pos_o = pos_q;

endmodule

`default_nettype wire

@@ hdl/sbc_addr.sv @@
// sbc_addr: clipping, colour key and framebuffer index stage with result register
// depends on sbc_pkg (cfg_t, pos_t) and sbc_out_if
`default_nettype none

module sbc_addr (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  sbc_pkg::cfg_t      cfg_i,
  input  wire logic          vld_i,
  input  sbc_pkg::pos_t      pos_i,
  output logic               adv_o,
  sbc_out_if.source          res_out
);

  logic                      vld_q, vld_d, load;
  logic                      strobe_q, done_q;
  logic [sbc_pkg::IdxW-1:0]  idx_q, idx_d;
  logic [sbc_pkg::PixW-1:0]  pix_q;
  logic                      on_screen, keyed;
  logic [sbc_pkg::CntW-1:0]  sx_lo, sy_lo;
  logic [sbc_pkg::ProdW-1:0] prod;

  // result register takes a word when empty or when the sink takes its word
  assign adv_o = !vld_q || res_out.ready;
  assign load  = vld_i && adv_o;

  // clip against the screen
  assign on_screen = (pos_i.sx >= 0)
                  && (pos_i.sx < $signed(sbc_pkg::PosW'(cfg_i.screen_w)))
                  && (pos_i.sy >= 0)
                  && (pos_i.sy < $signed(sbc_pkg::PosW'(cfg_i.screen_h)));

  assign keyed = cfg_i.key_en && (pos_i.pixel == cfg_i.key_colour);

  // linear index, row times stride plus column
  assign sx_lo = pos_i.sx[sbc_pkg::CntW-1:0];
  assign sy_lo = pos_i.sy[sbc_pkg::CntW-1:0];
  assign prod  = sbc_pkg::ProdW'(sy_lo) * sbc_pkg::ProdW'(cfg_i.screen_w)
               + sbc_pkg::ProdW'(sx_lo);
  assign idx_d = on_screen ? prod[sbc_pkg::IdxW-1:0] : '0;

  assign vld_d = load || (vld_q && !res_out.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      strobe_q <= on_screen && !keyed;
      idx_q    <= idx_d;
      pix_q    <= pos_i.pixel;
      done_q   <= pos_i.done;
    end
  end

  assign res_out.valid        = vld_q;
  assign res_out.write_strobe = strobe_q;
  assign res_out.pixel_index  = idx_q;
  assign res_out.pixel_value  = pix_q;
  assign res_out.sprite_done  = done_q;

endmodule

`default_nettype wire

@@ hdl/sprite_blit_colorkey_unit.sv @@
// sprite_blit_colorkey_unit: top level of the colour-keyed sprite blitter
// depends on sbc_pkg, sbc_if, sbc_cfg, sbc_pos and sbc_addr
//
// Usage:
//   sprite_i carries sprite pixels (RGB565) in row-major order, one per word.
//   result_o gives one word per pixel: write strobe, linear framebuffer index
//   (row * screen width + column), the pixel and a flag on the sprite's last
//   pixel. Pixels off the screen, or equal to the key colour while keying is
//   on, come out with the strobe low; off-screen pixels carry index zero.
//   The register port (cfg_we_i, cfg_idx_i, cfg_data_i) writes one register per
//   cycle; the user must write it while no pixel is in flight (not enforced).
//   An accepted pixel reaches its result word through two register stages
//   (position stage, then the clip/multiply stage feeding the result register);
//   one pixel is taken every cycle while the receiver does not stall.
//   When the receiver stalls, the result register holds its word; with the
//   position stage full, sprite_i.ready drops in the same cycle, and an empty
//   position stage takes one more pixel first, so at most two words wait.
//   Reset clears both stages, the column and row counters and loads the
//   register defaults (1x1 sprite at the origin, 1024x768 screen, no key).
`default_nettype none

module sprite_blit_colorkey_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [sbc_pkg::RegIdxW-1:0]   cfg_idx_i,
  input  wire logic [sbc_pkg::DataW-1:0]     cfg_data_i,
  sbc_in_if.sink                             sprite_i,
  sbc_out_if.source                          result_o
);

  sbc_pkg::cfg_t cfg;
  sbc_pkg::pos_t pos;
  logic          pos_vld, adv;

  // register file
  sbc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // counters and screen position
  sbc_pos u_pos (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .pix_in (sprite_i),
    .adv_i  (adv),
    .vld_o  (pos_vld),
    .pos_o  (pos)
  );

  // clipping, keying, index and result register
  sbc_addr u_addr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .vld_i   (pos_vld),
    .pos_i   (pos),
    .adv_o   (adv),
    .res_out (result_o)
  );

endmodule

`default_nettype wire

@@ dv/tb_sprite_blit_colorkey_unit.sv @@
// tb_sprite_blit_colorkey_unit: self-checking bench for the colour-keyed sprite blitter
// predicts every framebuffer write word from its own copy of registers and counters
// depends on sbc_pkg, sbc_if and the sprite_blit_colorkey_unit rtl
`default_nettype none

module tb_sprite_blit_colorkey_unit;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned SettleCycles = 4;

  // expected framebuffer write word
  typedef struct packed {
    logic                     strobe;
    logic [sbc_pkg::IdxW-1:0] index;
    logic [sbc_pkg::PixW-1:0] value;
    logic                     done;
  } fb_write_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  sbc_pkg::reg_idx_e cfg_idx_i;
  logic [sbc_pkg::DataW-1:0] cfg_data_i;

  sbc_in_if  pixel_ch ();
  sbc_out_if write_ch ();

  sprite_blit_colorkey_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .sprite_i   (pixel_ch),
    .result_o   (write_ch)
  );

  // shadow registers and sprite counters
  logic [sbc_pkg::CfgW-1:0] org_x = '0;
  logic [sbc_pkg::CfgW-1:0] org_y = '0;
  logic [sbc_pkg::CfgW-1:0] sprite_w = 12'd1;
  logic [sbc_pkg::CfgW-1:0] sprite_h = 12'd1;
  logic [sbc_pkg::CfgW-1:0] screen_w = 12'd1024;
  logic [sbc_pkg::CfgW-1:0] screen_h = 12'd768;
  logic [sbc_pkg::PixW-1:0] key_colour = '0;
  logic                     key_on = 1'b0;
  logic [sbc_pkg::CntW-1:0] col_pos = '0;
  logic [sbc_pkg::CntW-1:0] row_pos = '0;

  fb_write_t pending_writes[$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  bit source_idles = 1'b0;
  bit sink_idles = 1'b0;
  bit stall_request = 1'b0;
  int unsigned hold_left = 0;

  always #4 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // zero or oversize dimension counts as the largest one
  function automatic int clamp_dim(logic [sbc_pkg::CfgW-1:0] v);
    return ((v == '0) || (int'(v) > sbc_pkg::MaxDim)) ? int'(sbc_pkg::MaxDim) : int'(v);
  endfunction

  // screen position, clipping and keying of one pixel, then counter advance
  function automatic fb_write_t blit_pixel(logic [sbc_pkg::PixW-1:0] px);
    int sw, sh, fw, fh, sx, sy;
    bit on_screen, row_end, last_row;
    fb_write_t w;
    sw = clamp_dim(sprite_w);
    sh = clamp_dim(sprite_h);
    fw = clamp_dim(screen_w);
    fh = clamp_dim(screen_h);
    sx = int'($signed(org_x)) + int'(col_pos);
    sy = int'($signed(org_y)) + int'(row_pos);
    on_screen = (sx >= 0) && (sx < fw) && (sy >= 0) && (sy < fh);
    row_end = (int'(col_pos) + 1) >= sw;
    last_row = (int'(row_pos) + 1) >= sh;
    w.strobe = on_screen && !(key_on && (px == key_colour));
    w.index = on_screen ? sbc_pkg::IdxW'(sy * fw + sx) : '0;
    w.value = px;
    w.done = row_end && last_row;
    if (row_end) begin
      col_pos = '0;
      row_pos = last_row ? '0 : row_pos + 1'b1;
    end else begin
      col_pos = col_pos + 1'b1;
    end
    return w;
  endfunction

  function automatic void note_mismatch(string what);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] mismatch: %s", $realtime, what);
  endfunction

  // compare every write word with the oldest prediction
  always @(posedge clk_i) begin
    fb_write_t want;
    if (rst_ni && write_ch.valid && write_ch.ready) begin
      if (pending_writes.size() == 0) begin
        note_mismatch($sformatf("unexpected word strobe=%0b index=%0d value=%h done=%0b",
                                write_ch.write_strobe, write_ch.pixel_index,
                                write_ch.pixel_value, write_ch.sprite_done));
      end else begin
        want = pending_writes.pop_front();
        if (write_ch.write_strobe !== want.strobe || write_ch.pixel_index !== want.index ||
            write_ch.pixel_value !== want.value || write_ch.sprite_done !== want.done) begin
          note_mismatch($sformatf(
            "expected strobe=%0b index=%0d value=%h done=%0b, got %0b %0d %h %0b",
            want.strobe, want.index, want.value, want.done, write_ch.write_strobe,
            write_ch.pixel_index, write_ch.pixel_value, write_ch.sprite_done));
        end
      end
    end
  end

  // receiver: random idling, or a long hold-off on request
  initial begin
    write_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_request) begin
        stall_request = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        write_ch.ready <= 1'b0;
      end else if (sink_idles) begin
        write_ch.ready <= ($urandom_range(99) >= 27);
      end else begin
        write_ch.ready <= 1'b1;
      end
    end
  end

  // offer one pixel word, called and returning at a falling edge
  task automatic send_pixel(logic [sbc_pkg::PixW-1:0] px);
    while (source_idles && $urandom_range(99) < 27) begin
      pixel_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    pixel_ch.valid <= 1'b1;
    pixel_ch.sprite_pixel <= px;
    do @(posedge clk_i); while (!pixel_ch.ready);
    pending_writes.push_back(blit_pixel(px));
    @(negedge clk_i);
  endtask

  // stop offering and let the pipeline empty
  task automatic wait_idle();
    pixel_ch.valid <= 1'b0;
    while (pending_writes.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(sbc_pkg::reg_idx_e idx, logic [sbc_pkg::DataW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      sbc_pkg::REG_DEST_X:        org_x = data[sbc_pkg::CfgW-1:0];
      sbc_pkg::REG_DEST_Y:        org_y = data[sbc_pkg::CfgW-1:0];
      sbc_pkg::REG_SPRITE_WIDTH:  sprite_w = data[sbc_pkg::CfgW-1:0];
      sbc_pkg::REG_SPRITE_HEIGHT: sprite_h = data[sbc_pkg::CfgW-1:0];
      sbc_pkg::REG_SCREEN_WIDTH:  screen_w = data[sbc_pkg::CfgW-1:0];
      sbc_pkg::REG_SCREEN_HEIGHT: screen_h = data[sbc_pkg::CfgW-1:0];
      sbc_pkg::REG_KEY_COLOUR:    key_colour = data[sbc_pkg::PixW-1:0];
      sbc_pkg::REG_KEY_ENABLE:    key_on = data[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // register values biased towards small sprites and screens, with extremes
  function automatic logic [sbc_pkg::DataW-1:0] pick_reg_value(sbc_pkg::reg_idx_e idx);
    logic [sbc_pkg::CfgW-1:0] v;
    int unsigned r;
    r = $urandom_range(9);
    case (idx)
      sbc_pkg::REG_DEST_X, sbc_pkg::REG_DEST_Y: begin
        v = (r < 7) ? sbc_pkg::CfgW'(int'($urandom_range(40)) - 16)
                    : sbc_pkg::CfgW'($urandom);
      end
      sbc_pkg::REG_SPRITE_WIDTH, sbc_pkg::REG_SPRITE_HEIGHT: begin
        if (r < 8) v = sbc_pkg::CfgW'($urandom_range(1, 12));
        else if (r == 8) v = '0;
        else v = sbc_pkg::CfgW'($urandom_range(2048, 4095));
      end
      sbc_pkg::REG_SCREEN_WIDTH, sbc_pkg::REG_SCREEN_HEIGHT: begin
        if (r < 6) v = sbc_pkg::CfgW'($urandom_range(1, 24));
        else if (r < 8) v = sbc_pkg::CfgW'($urandom_range(1, 4095));
        else v = $urandom_range(1) ? 12'd2048 : '0;
      end
      sbc_pkg::REG_KEY_COLOUR:    return sbc_pkg::DataW'($urandom);
      sbc_pkg::REG_KEY_ENABLE:    return {15'($urandom), 1'($urandom)};
      default:                    v = '0;
    endcase
    // upper data bits are junk the register must drop
    return {4'($urandom), v};
  endfunction

  // pixels often equal to, or one bit away from, the key colour
  function automatic logic [sbc_pkg::PixW-1:0] pick_pixel();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 25) return key_colour;
    if (r < 30) return key_colour ^ (sbc_pkg::PixW'(1) << $urandom_range(sbc_pkg::PixW - 1));
    if (r < 35) return $urandom_range(1) ? 16'hFFFF : 16'h0000;
    return sbc_pkg::PixW'($urandom);
  endfunction

  // rewrite a random subset of registers, leaving the counters where they are
  task automatic randomise_setup();
    for (int i = 0; i < 8; i++) begin
      if ($urandom_range(3) != 0) begin
        write_reg(sbc_pkg::reg_idx_e'(i), pick_reg_value(sbc_pkg::reg_idx_e'(i)));
      end
    end
  endtask

  // 1x1 sprite at the origin after reset, key colour matches but keying is off
  task automatic test_reset_defaults();
    send_pixel(16'h0000);
    send_pixel(16'hFFFF);
    send_pixel(16'hA5A5);
  endtask

  // 5x3 sprite over a 3x1 screen: clipping on every side, keyed pixels on and off screen
  task automatic test_clip_and_key();
    wait_idle();
    write_reg(sbc_pkg::REG_DEST_X, 16'h0FFF);
    write_reg(sbc_pkg::REG_DEST_Y, 16'hFFFF);
    write_reg(sbc_pkg::REG_SPRITE_WIDTH, 16'd5);
    write_reg(sbc_pkg::REG_SPRITE_HEIGHT, 16'd3);
    write_reg(sbc_pkg::REG_SCREEN_WIDTH, 16'd3);
    write_reg(sbc_pkg::REG_SCREEN_HEIGHT, 16'd1);
    write_reg(sbc_pkg::REG_KEY_COLOUR, 16'hF81F);
    write_reg(sbc_pkg::REG_KEY_ENABLE, 16'h0001);
    for (int i = 0; i < 15; i++) begin
      if (i % 3 == 0) send_pixel(16'hF81F);
      else if (i == 7) send_pixel(16'hF81E);
      else send_pixel(sbc_pkg::PixW'($urandom));
    end
  endtask

  // clamped dimensions, far corners of the coordinate range, shrink mid-row
  task automatic test_extremes();
    wait_idle();
    write_reg(sbc_pkg::REG_KEY_ENABLE, 16'h0000);
    write_reg(sbc_pkg::REG_SCREEN_WIDTH, 16'h0000);
    write_reg(sbc_pkg::REG_SCREEN_HEIGHT, 16'hFFFF);
    write_reg(sbc_pkg::REG_SPRITE_WIDTH, 16'd1);
    write_reg(sbc_pkg::REG_SPRITE_HEIGHT, 16'd1);
    write_reg(sbc_pkg::REG_DEST_X, 16'h07FF);
    write_reg(sbc_pkg::REG_DEST_Y, 16'h07FF);
    send_pixel(16'h8001);
    wait_idle();
    write_reg(sbc_pkg::REG_DEST_X, 16'h0800);
    write_reg(sbc_pkg::REG_DEST_Y, 16'h0800);
    send_pixel(16'h7FFE);
    wait_idle();
    write_reg(sbc_pkg::REG_DEST_X, 16'h0000);
    write_reg(sbc_pkg::REG_DEST_Y, 16'h0000);
    write_reg(sbc_pkg::REG_SPRITE_WIDTH, 16'h0000);
    write_reg(sbc_pkg::REG_SPRITE_HEIGHT, 16'd2);
    repeat (3) send_pixel(sbc_pkg::PixW'($urandom));
    // column counter now past the new row end
    wait_idle();
    write_reg(sbc_pkg::REG_SPRITE_WIDTH, 16'd2);
    repeat (2) send_pixel(sbc_pkg::PixW'($urandom));
  endtask

  task automatic test_random_sprites(int unsigned n_items);
    int unsigned sent;
    int unsigned burst;
    sent = 0;
    source_idles = 1'b1;
    sink_idles = 1'b1;
    while (sent < n_items) begin
      wait_idle();
      randomise_setup();
      burst = $urandom_range(1, 40);
      repeat (burst) send_pixel(pick_pixel());
      sent += burst;
    end
  endtask

  // back to back words, no idling on either side
  task automatic test_full_rate(int unsigned n_items);
    wait_idle();
    source_idles = 1'b0;
    sink_idles = 1'b0;
    randomise_setup();
    repeat (n_items) send_pixel(pick_pixel());
  endtask

  // receiver holds off while pixels keep coming, so the input stalls
  task automatic test_backpressure();
    wait_idle();
    source_idles = 1'b0;
    sink_idles = 1'b0;
    stall_request = 1'b1;
    @(negedge clk_i);
    repeat (24) send_pixel(pick_pixel());
    sink_idles = 1'b1;
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = sbc_pkg::REG_DEST_X;
    cfg_data_i = '0;
    pixel_ch.valid = 1'b0;
    pixel_ch.sprite_pixel = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_defaults();
    test_clip_and_key();
    test_extremes();
    test_random_sprites(650);
    test_full_rate(150);
    test_backpressure();

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sprite_blit_colorkey_unit.f @@
hdl/sbc_pkg.sv
hdl/sbc_if.sv
hdl/sbc_cfg.sv
hdl/sbc_pos.sv
hdl/sbc_addr.sv
hdl/sprite_blit_colorkey_unit.sv
dv/tb_sprite_blit_colorkey_unit.sv
